// ----- hw/rtl/cdq_pkg.sv -----
// Shared types, constants and helper functions for the coordinate deque.
// Used by every RTL file of the block but cdq_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  // Sizing
  localparam int GRID_SIDE   = 32;
  localparam int DEQUE_DEPTH = 1024;

  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int GRID_AW    = $clog2(GRID_CELLS);
  localparam int RING_AW    = $clog2(DEQUE_DEPTH);
  localparam int CNT_W      = $clog2(DEQUE_DEPTH + 1);

  // Field widths
  localparam int MODE_W   = 3;
  localparam int COORD_W  = 5;
  localparam int MARK_W   = 2;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 11;
  localparam int PT_W     = 2 * COORD_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_REAR  = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_REAR  = 3'd3,
    MODE_WRITE     = 3'd4,
    MODE_QUERY     = 3'd5
  } cdq_mode_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_BODY  = 2'd1,
    MARK_FOOD  = 2'd2,
    MARK_OTHER = 2'd3
  } cdq_mark_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } cdq_status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FINISH
  } cdq_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cdq_pt_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write one grid cell of the clearing pass
    logic issue;   // take the input word, start the step
    logic finish;  // complete the step, load the result register
  } cdq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last cell
    logic slot_free;   // result register is empty or is being taken
  } cdq_stat_t;

  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] idx);
    return (idx == RING_AW'(DEQUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [RING_AW-1:0] ring_dec(input logic [RING_AW-1:0] idx);
    return (idx == '0) ? RING_AW'(DEQUE_DEPTH - 1) : idx - 1'b1;
  endfunction

  function automatic logic in_grid(input cdq_pt_t pt);
    return (int'(pt.x) < GRID_SIDE) && (int'(pt.y) < GRID_SIDE);
  endfunction

  function automatic logic [GRID_AW-1:0] grid_addr(input cdq_pt_t pt);
    return GRID_AW'(int'(pt.x) * GRID_SIDE + int'(pt.y));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cdq_if.sv -----
// Valid/ready channel interfaces for the input word and the result word.
// Depends on cdq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdq_in_if;
  logic                            valid;
  logic                            ready;
  logic [cdq_pkg::MODE_W-1:0]      mode;
  logic [cdq_pkg::COORD_W-1:0]     cell_x;
  logic [cdq_pkg::COORD_W-1:0]     cell_y;
  logic [cdq_pkg::MARK_W-1:0]      mark_value;

  modport source (output valid, mode, cell_x, cell_y, mark_value, input ready);
  modport sink   (input valid, mode, cell_x, cell_y, mark_value, output ready);
endinterface

interface cdq_out_if;
  logic                            valid;
  logic                            ready;
  logic [cdq_pkg::STATUS_W-1:0]    status;
  logic [cdq_pkg::COORD_W-1:0]     front_x;
  logic [cdq_pkg::COORD_W-1:0]     front_y;
  logic [cdq_pkg::COORD_W-1:0]     rear_x;
  logic [cdq_pkg::COORD_W-1:0]     rear_y;
  logic [cdq_pkg::LEN_W-1:0]       length;

  modport source (output valid, status, front_x, front_y, rear_x, rear_y, length,
                  input ready);
  modport sink   (input valid, status, front_x, front_y, rear_x, rear_y, length,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cdq_ctrl.sv -----
// Sequencer for the coordinate deque: clearing pass, issue and finish.
// Depends on cdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cdq_pkg::cdq_stat_t stat_i,
  output cdq_pkg::cdq_cmd_t  cmd_o
);
  import cdq_pkg::*;

  cdq_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.issue = in_valid_i;
      end
      ST_FINISH: begin
        cmd_o.finish = stat_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cdq_datapath.sv -----
// Ring pointers, point ring, grid marks and result register of the deque.
// Depends on cdq_pkg and cdq_ram.
`timescale 1ns / 1ps
`default_nettype none

module cdq_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cdq_pkg::cdq_cmd_t               cmd_i,
  output cdq_pkg::cdq_stat_t              stat_o,
  input  logic [cdq_pkg::MODE_W-1:0]      mode_i,
  input  logic [cdq_pkg::COORD_W-1:0]     cell_x_i,
  input  logic [cdq_pkg::COORD_W-1:0]     cell_y_i,
  input  logic [cdq_pkg::MARK_W-1:0]      mark_value_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [cdq_pkg::STATUS_W-1:0]    status_o,
  output logic [cdq_pkg::COORD_W-1:0]     front_x_o,
  output logic [cdq_pkg::COORD_W-1:0]     front_y_o,
  output logic [cdq_pkg::COORD_W-1:0]     rear_x_o,
  output logic [cdq_pkg::COORD_W-1:0]     rear_y_o,
  output logic [cdq_pkg::LEN_W-1:0]       length_o
);
  import cdq_pkg::*;

  // Deque state
  logic [RING_AW-1:0] front_idx_q, front_idx_d;
  logic [RING_AW-1:0] rear_idx_q, rear_idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  cdq_pt_t            front_pt_q, front_pt_d;
  cdq_pt_t            rear_pt_q, rear_pt_d;

  // Step in flight
  logic               upd_front_q, upd_front_d;
  logic               upd_rear_q, upd_rear_d;
  logic               rel_pend_q, rel_pend_d;
  logic [GRID_AW-1:0] rel_addr_q, rel_addr_d;
  cdq_status_e        st_q, st_d;

  // Clearing pass
  logic [GRID_AW-1:0] clr_q;

  // Result register
  logic               out_valid_q;
  cdq_status_e        out_st_q;
  cdq_pt_t            out_front_q, out_rear_q;
  logic [LEN_W-1:0]   out_len_q;

  // Memory ports
  logic               ring_we, ring_re;
  logic [RING_AW-1:0] ring_waddr, ring_raddr;
  logic [PT_W-1:0]    ring_rdata;
  logic               grid_we, grid_re;
  logic [GRID_AW-1:0] grid_waddr, grid_raddr;
  logic [MARK_W-1:0]  grid_wdata, grid_rdata;

  cdq_mode_e mode;
  cdq_pt_t   in_pt, del_pt, front_n, rear_n;
  logic      is_ins, is_del, full, empty, ins_ok, del_ok;

  assign mode    = cdq_mode_e'(mode_i);
  assign in_pt.x = cell_x_i;
  assign in_pt.y = cell_y_i;
  assign is_ins  = (mode == MODE_INS_FRONT) || (mode == MODE_INS_REAR);
  assign is_del  = (mode == MODE_DEL_FRONT) || (mode == MODE_DEL_REAR);
  assign full    = (count_q == CNT_W'(DEQUE_DEPTH));
  assign empty   = (count_q == '0);
  assign ins_ok  = is_ins && !full;
  assign del_ok  = is_del && !empty;
  assign del_pt  = (mode == MODE_DEL_FRONT) ? front_pt_q : rear_pt_q;

  // New end points once the neighbor read of a delete has returned
  assign front_n = upd_front_q ? cdq_pt_t'(ring_rdata) : front_pt_q;
  assign rear_n  = upd_rear_q  ? cdq_pt_t'(ring_rdata) : rear_pt_q;

  // Ring port: write on insert, read the neighbor of the deleted end (the new end) on delete
  assign ring_we    = cmd_i.issue && ins_ok;
  assign ring_waddr = (mode == MODE_INS_FRONT) ? ring_dec(front_idx_q) : ring_inc(rear_idx_q);
  assign ring_re    = cmd_i.issue && del_ok;
  assign ring_raddr = (mode == MODE_DEL_FRONT) ? ring_inc(front_idx_q) : ring_dec(rear_idx_q);

  // Grid read of the cell being released
  assign grid_re    = cmd_i.issue && del_ok;
  assign grid_raddr = grid_addr(del_pt);

  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = grid_addr(in_pt);
    grid_wdata = MARK_EMPTY;
    if (cmd_i.clear) begin
      grid_we    = 1'b1;
      grid_waddr = clr_q;
    end else if (cmd_i.issue && ins_ok && in_grid(in_pt)) begin
      grid_we    = 1'b1;
      grid_wdata = MARK_BODY;
    end else if (cmd_i.issue && (mode == MODE_WRITE) && in_grid(in_pt)) begin
      grid_we    = 1'b1;
      grid_wdata = mark_value_i;
    end else if (cmd_i.finish && rel_pend_q && (grid_rdata != MARK_FOOD)) begin
      grid_we    = 1'b1;
      grid_waddr = rel_addr_q;
    end
  end

  always_comb begin
    front_idx_d = front_idx_q;
    rear_idx_d  = rear_idx_q;
    count_d     = count_q;
    front_pt_d  = front_pt_q;
    rear_pt_d   = rear_pt_q;
    upd_front_d = upd_front_q;
    upd_rear_d  = upd_rear_q;
    rel_pend_d  = rel_pend_q;
    rel_addr_d  = rel_addr_q;
    st_d        = st_q;
    if (cmd_i.issue) begin
      upd_front_d = 1'b0;
      upd_rear_d  = 1'b0;
      rel_pend_d  = del_ok && in_grid(del_pt);
      rel_addr_d  = grid_addr(del_pt);
      st_d        = STAT_DONE;
      if (is_ins && full) st_d = STAT_FULL;
      if (is_del && empty) st_d = STAT_EMPTY;
      case (mode)
        MODE_INS_FRONT: begin
          if (ins_ok) begin
            front_idx_d = ring_dec(front_idx_q);
            count_d     = count_q + 1'b1;
            front_pt_d  = in_pt;
            if (empty) rear_pt_d = in_pt;
          end
        end
        MODE_INS_REAR: begin
          if (ins_ok) begin
            rear_idx_d = ring_inc(rear_idx_q);
            count_d    = count_q + 1'b1;
            rear_pt_d  = in_pt;
            if (empty) front_pt_d = in_pt;
          end
        end
        MODE_DEL_FRONT: begin
          if (del_ok) begin
            front_idx_d = ring_inc(front_idx_q);
            count_d     = count_q - 1'b1;
            upd_front_d = 1'b1;
          end
        end
        MODE_DEL_REAR: begin
          if (del_ok) begin
            rear_idx_d = ring_dec(rear_idx_q);
            count_d    = count_q - 1'b1;
            upd_rear_d = 1'b1;
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end else if (cmd_i.finish) begin
      front_pt_d = front_n;
      rear_pt_d  = rear_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx_q <= '0;
      rear_idx_q  <= RING_AW'(DEQUE_DEPTH - 1);
      count_q     <= '0;
      upd_front_q <= 1'b0;
      upd_rear_q  <= 1'b0;
      rel_pend_q  <= 1'b0;
      st_q        <= STAT_DONE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_idx_q <= front_idx_d;
      rear_idx_q  <= rear_idx_d;
      count_q     <= count_d;
      upd_front_q <= upd_front_d;
      upd_rear_q  <= upd_rear_d;
      rel_pend_q  <= rel_pend_d;
      st_q        <= st_d;
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    front_pt_q <= front_pt_d;
    rear_pt_q  <= rear_pt_d;
    rel_addr_q <= rel_addr_d;
    if (cmd_i.finish) begin
      out_st_q    <= st_q;
      out_front_q <= empty ? '0 : front_n;
      out_rear_q  <= empty ? '0 : rear_n;
      out_len_q   <= LEN_W'(count_q);
    end
  end

  cdq_ram #(.WIDTH(PT_W), .DEPTH(DEQUE_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (in_pt),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  cdq_ram #(.WIDTH(MARK_W), .DEPTH(GRID_CELLS)) u_grid (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .re_i    (grid_re),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  assign stat_o.clear_last = (clr_q == GRID_AW'(GRID_CELLS - 1));
  assign stat_o.slot_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign front_x_o   = out_front_q.x;
  assign front_y_o   = out_front_q.y;
  assign rear_x_o    = out_rear_q.x;
  assign rear_y_o    = out_rear_q.y;
  assign length_o    = out_len_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEQUE_DEPTH))
    else $error("element count above deque depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (ring_inc(rear_idx_q) == front_idx_q))
    else $error("ring pointers disagree with an empty deque");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.issue && (cmd_i.finish || cmd_i.clear)))
    else $error("issue overlaps finish or clearing");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result appeared without a finished step");

endmodule

`default_nettype wire

// ----- hw/rtl/coordinate_deque_with_grid_marks_top.sv -----
// Top level of the coordinate deque with grid marks.
// Flow: a word is accepted in the idle state and finished once the result register is free.
// Pacing: the input is not ready while a word is being finished, in every mode; a delete
//   reads the grid mark when it is accepted and clears it, unless it is food, at finish.
// Reset: asynchronous, active low; then a clearing pass writes all 1024 grid cells
//   empty, one per cycle, with the input held not ready.
`timescale 1ns / 1ps
`default_nettype none

module coordinate_deque_with_grid_marks_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdq_in_if.sink     in_i,
  cdq_out_if.source  out_o
);
  import cdq_pkg::*;

  cdq_cmd_t  cmd;
  cdq_stat_t stat;

  // Sequencer: owns the handshake on the input side and paces the datapath.
  cdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: ring of points, grid of marks, end pointers and the result
  // register that holds a finished word while the next one is taken in.
  cdq_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (in_i.mode),
    .cell_x_i     (in_i.cell_x),
    .cell_y_i     (in_i.cell_y),
    .mark_value_i (in_i.mark_value),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .status_o     (out_o.status),
    .front_x_o    (out_o.front_x),
    .front_y_o    (out_o.front_y),
    .rear_x_o     (out_o.rear_x),
    .rear_y_o     (out_o.rear_y),
    .length_o     (out_o.length)
  );

endmodule

`default_nettype wire

// ----- sim/tb_coordinate_deque_with_grid_marks_top.sv -----
// Self-checking testbench for coordinate_deque_with_grid_marks_top: drives command words,
// predicts each result word from its own deque and grid state and checks every field.
// Depends on cdq_pkg, cdq_if.sv and the RTL of the block.
`timescale 1ns / 1ps

module tb_coordinate_deque_with_grid_marks_top;
  import cdq_pkg::*;

  // Modes six and seven are unused codes that the block treats as a query.
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  // Worst correct run: the clearing pass plus about 750 words, stretched by sender gaps
  // and receiver stalls, stays below CYCLE_LIMIT.
  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [MARK_W-1:0]  mark;
  } deque_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  front_x;
    logic [COORD_W-1:0]  front_y;
    logic [COORD_W-1:0]  rear_x;
    logic [COORD_W-1:0]  rear_y;
    logic [LEN_W-1:0]    length;
  } deque_view_t;

  logic clk_i;
  logic rst_ni;

  cdq_in_if  in_if ();
  cdq_out_if out_if ();

  coordinate_deque_with_grid_marks_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Command words waiting to be sent, and result words still owed by the block.
  deque_cmd_t  pending_cmds[$];
  deque_view_t expected_views[$];

  int err_cnt        = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit in_fire        = 1'b0;  // command word taken at the last rising edge

  // Shadow of the block: ring of points, front position, count and grid marks.
  logic [PT_W-1:0] ring_pt [DEQUE_DEPTH];
  int unsigned     head_pos = 0;
  int unsigned     held     = 0;
  cdq_mark_e       marks [GRID_CELLS];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Write one grid mark; a cell outside the grid is left alone. On a delete,
  // spare_food keeps a food cell as it is.
  function automatic void set_cell(input logic [COORD_W-1:0] x, y, input cdq_mark_e m,
                                   input bit spare_food);
    int unsigned idx;
    if (x < GRID_SIDE && y < GRID_SIDE) begin
      idx = x * GRID_SIDE + y;
      if (!(spare_food && marks[idx] == MARK_FOOD)) marks[idx] = m;
    end
  endfunction

  // Apply one accepted command to the shadow state and return the result word it owes.
  function automatic deque_view_t next_view(input deque_cmd_t c);
    deque_view_t     v;
    int unsigned     pos;
    logic [PT_W-1:0] pt;
    v        = '0;
    v.status = STAT_DONE;
    case (c.mode)
      MODE_INS_FRONT, MODE_INS_REAR: begin
        if (held >= DEQUE_DEPTH) begin
          v.status = STAT_FULL;
        end else begin
          if (c.mode == MODE_INS_FRONT) begin
            head_pos = (head_pos + DEQUE_DEPTH - 1) % DEQUE_DEPTH;
            pos      = head_pos;
          end else begin
            pos = (head_pos + held) % DEQUE_DEPTH;
          end
          ring_pt[pos] = {c.x, c.y};
          held++;
          set_cell(c.x, c.y, MARK_BODY, 1'b0);
        end
      end
      MODE_DEL_FRONT, MODE_DEL_REAR: begin
        if (held == 0) begin
          v.status = STAT_EMPTY;
        end else begin
          pos = (c.mode == MODE_DEL_FRONT) ? head_pos : (head_pos + held - 1) % DEQUE_DEPTH;
          pt  = ring_pt[pos];
          set_cell(pt[PT_W-1:COORD_W], pt[COORD_W-1:0], MARK_EMPTY, 1'b1);
          if (c.mode == MODE_DEL_FRONT) head_pos = (head_pos + 1) % DEQUE_DEPTH;
          held--;
        end
      end
      MODE_WRITE: set_cell(c.x, c.y, cdq_mark_e'(c.mark), 1'b0);
      default: ;
    endcase
    // An empty deque reports zero for both end points.
    if (held != 0) begin
      {v.front_x, v.front_y} = ring_pt[head_pos];
      {v.rear_x, v.rear_y}   = ring_pt[(head_pos + held - 1) % DEQUE_DEPTH];
    end
    v.length = LEN_W'(held);
    return v;
  endfunction

  // Random command: ins_pct inserts, del_pct deletes, the rest writes, queries and the unused modes.
  function automatic deque_cmd_t random_cmd(input int ins_pct, input int del_pct);
    deque_cmd_t c;
    int         r;
    r      = $urandom_range(99);
    c.x    = COORD_W'($urandom_range(31));
    c.y    = COORD_W'($urandom_range(31));
    c.mark = MARK_W'($urandom_range(3));
    if (r < ins_pct) begin
      c.mode = $urandom_range(1) ? MODE_INS_REAR : MODE_INS_FRONT;
    end else if (r < ins_pct + del_pct) begin
      c.mode = $urandom_range(1) ? MODE_DEL_REAR : MODE_DEL_FRONT;
    end else begin
      case ($urandom_range(4))
        0, 1:    c.mode = MODE_WRITE;
        2:       c.mode = MODE_QUERY;
        3:       c.mode = MODE_SPARE6;
        default: c.mode = MODE_SPARE7;
      endcase
    end
    return c;
  endfunction

  task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] x, y,
                           input logic [MARK_W-1:0] mark);
    pending_cmds.push_back({mode, x, y, mark});
  endtask

  // Hold off until every queued word is sent and every result word has come back.
  task automatic wait_quiet();
    while (pending_cmds.size() != 0 || in_if.valid !== 1'b0 || expected_views.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic flag_field(input string name, input logic [LEN_W-1:0] want, got);
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    err_cnt++;
  endtask

  // Driver: advance to the next command word once the current one is taken, or
  // drop valid for an idle cycle; hold the word while the block is not ready.
  always @(negedge clk_i) begin : drive_words
    deque_cmd_t nxt;
    if (rst_ni) begin
      if (!in_if.valid || in_fire) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_cmds.pop_front();
          {in_if.mode, in_if.cell_x, in_if.cell_y, in_if.mark_value} <= nxt;
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on every accepted command word, check every accepted result word.
  // Push before checking, so a result word at the same edge still finds its slot.
  always @(posedge clk_i) begin : watch_words
    deque_view_t got;
    deque_view_t want;
    if (!rst_ni) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_if.valid && in_if.ready;
      if (in_fire)
        expected_views.push_back(
          next_view({in_if.mode, in_if.cell_x, in_if.cell_y, in_if.mark_value}));
      if (out_if.valid && out_if.ready) begin
        got = {out_if.status, out_if.front_x, out_if.front_y, out_if.rear_x, out_if.rear_y,
               out_if.length};
        if (expected_views.size() == 0) begin
          $display("%0t: result word with nothing outstanding: expected none, got %h",
                   $time, got);
          err_cnt++;
        end else begin
          want = expected_views.pop_front();
          if (got.status !== want.status)
            flag_field("status", LEN_W'(want.status), LEN_W'(got.status));
          if (got.front_x !== want.front_x)
            flag_field("front_x", LEN_W'(want.front_x), LEN_W'(got.front_x));
          if (got.front_y !== want.front_y)
            flag_field("front_y", LEN_W'(want.front_y), LEN_W'(got.front_y));
          if (got.rear_x !== want.rear_x)
            flag_field("rear_x", LEN_W'(want.rear_x), LEN_W'(got.rear_x));
          if (got.rear_y !== want.rear_y)
            flag_field("rear_y", LEN_W'(want.rear_y), LEN_W'(got.rear_y));
          if (got.length !== want.length)
            flag_field("length", want.length, got.length);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : run_test
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_QUERY;
    in_if.cell_x     = '0;
    in_if.cell_y     = '0;
    in_if.mark_value = '0;
    out_if.ready     = 1'b0;
    rst_ni           = 1'b0;
    foreach (marks[i]) marks[i] = MARK_EMPTY;
    foreach (ring_pt[i]) ring_pt[i] = '0;

    // Directed: empty deque, rejected deletes, insert into empty and delete of the
    // only point at both ends, coordinate and mark extremes, the unused modes.
    queue_cmd(MODE_QUERY,     5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_DEL_FRONT, 5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_DEL_REAR,  5'd31, 5'd31, MARK_OTHER);
    queue_cmd(MODE_INS_FRONT, 5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_DEL_FRONT, 5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_INS_REAR,  5'd31, 5'd31, MARK_OTHER);
    queue_cmd(MODE_DEL_REAR,  5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_INS_FRONT, 5'd31, 5'd0,  MARK_EMPTY);
    queue_cmd(MODE_INS_REAR,  5'd0,  5'd31, MARK_EMPTY);
    queue_cmd(MODE_INS_FRONT, 5'd21, 5'd10, MARK_BODY);
    queue_cmd(MODE_WRITE,     5'd0,  5'd31, MARK_FOOD);   // food on a body cell
    queue_cmd(MODE_WRITE,     5'd31, 5'd0,  MARK_OTHER);
    queue_cmd(MODE_WRITE,     5'd10, 5'd21, MARK_BODY);
    queue_cmd(MODE_WRITE,     5'd21, 5'd10, MARK_EMPTY);
    queue_cmd(MODE_SPARE6,    5'd31, 5'd31, MARK_OTHER);
    queue_cmd(MODE_SPARE7,    5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_QUERY,     5'd31, 5'd31, MARK_OTHER);
    queue_cmd(MODE_DEL_REAR,  5'd0,  5'd0,  MARK_EMPTY);  // food cell survives
    queue_cmd(MODE_DEL_FRONT, 5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_DEL_FRONT, 5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_DEL_REAR,  5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_INS_REAR,  5'd31, 5'd31, MARK_EMPTY);  // same cell twice
    queue_cmd(MODE_INS_FRONT, 5'd31, 5'd31, MARK_EMPTY);
    queue_cmd(MODE_DEL_FRONT, 5'd0,  5'd0,  MARK_EMPTY);
    queue_cmd(MODE_DEL_REAR,  5'd0,  5'd0,  MARK_EMPTY);

    // Insert-heavy run with no idling, with a write or query now and then.
    repeat (220) begin
      pending_cmds.push_back(random_cmd(100, 0));
      if ($urandom_range(15) == 0) pending_cmds.push_back(random_cmd(0, 0));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait_quiet();

    // Mixed traffic, sender idle with a chance of 67 percent.
    send_idle_pct  = 67;
    recv_stall_pct = 0;
    repeat (120) pending_cmds.push_back(random_cmd(40, 35));
    wait_quiet();

    // Drain past empty, receiver stalling with a chance of 67 percent.
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    repeat (260) begin
      pending_cmds.push_back(random_cmd(0, 100));
      if ($urandom_range(15) == 0) pending_cmds.push_back(random_cmd(0, 0));
    end
    wait_quiet();

    // Mixed traffic from empty, both sides idling now and then.
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    repeat (100) pending_cmds.push_back(random_cmd(45, 35));
    wait_quiet();

    // Let a stray result word show up before closing.
    repeat (8) @(posedge clk_i);
    if (expected_views.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_views.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- coordinate_deque_with_grid_marks_top.f -----
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_if.sv
hw/rtl/cdq_ram.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/cdq_datapath.sv
hw/rtl/coordinate_deque_with_grid_marks_top.sv
sim/tb_coordinate_deque_with_grid_marks_top.sv
